@@ rtl/sha256_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_pkg
// types, state codes and round constants for the sha-256 hash engine
// ----------------------------------------------------------------------------
package sha256_pkg;

    localparam logic KIND_BYTE   = 1'b0;
    localparam logic KIND_FINISH = 1'b1;

    localparam logic [7:0] PAD_MARK = 8'h80;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
    } item_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_COMP,
        ST_ADD,
        ST_LOAD
    } state_t;

    localparam logic [31:0] INIT_H [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

endpackage

@@ rtl/sha256_hash_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_hash_engine
// byte-serial sha-256 with padding, one compression round per cycle
// ----------------------------------------------------------------------------
// a message byte is taken while idle; the 64th byte of a block then adds
// (64 rounds through the shared round unit plus one hash update step)
// finish: one pad byte per cycle up to the block end (one or two blocks),
// each padded block is compressed, one load step once the previous digest has
// drained, then 8 digest beats; new bytes are taken while digest beats drain
// rst_n clears state asynchronously and loads the initial hash values
module sha256_hash_engine
    import sha256_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_stall,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    state_t       state_reg, state_next;
    logic [5:0]   fill_reg, fill_next;
    logic [5:0]   round_reg, round_next;
    logic [63:0]  msg_bits_reg, msg_bits_next;
    logic         pad_first_reg, pad_first_next;
    logic         len_ok_reg, len_ok_next;
    logic         final_reg, final_next;
    logic         out_busy_reg, out_busy_next;
    logic [2:0]   out_idx_reg, out_idx_next;
    logic [31:0]  hash_reg [8];
    logic [31:0]  hash_next [8];
    logic [31:0]  v_reg [8];
    logic [31:0]  v_next [8];
    logic [31:0]  out_buf_reg [8];
    logic [31:0]  out_buf_next [8];
    logic [511:0] blk_reg, blk_next;

    logic         item_beat;
    logic         result_beat;
    logic         use_len;
    logic [7:0]   pad_byte;
    logic [31:0]  w_new;
    logic [31:0]  t1;
    logic [31:0]  t2;

    function automatic logic [31:0] ror(input logic [31:0] x, input int n);
        ror = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] wd(input logic [511:0] b, input int i);
        wd = b[i*32 +: 32];
    endfunction

    assign item_beat   = item_valid && !item_stall;
    assign result_beat = result_valid && !result_stall;
    assign use_len     = !pad_first_reg && len_ok_reg && (fill_reg[5:3] == 3'b111);

    always_comb
    begin
        if (pad_first_reg)
        begin
            pad_byte = PAD_MARK;
        end
        else if (use_len)
        begin
            pad_byte = msg_bits_reg[63:56];
        end
        else
        begin
            pad_byte = 8'h00;
        end
    end

    // round unit and schedule
    always_comb
    begin
        logic [31:0] w14;
        logic [31:0] w1;
        logic [31:0] s0;
        logic [31:0] s1;
        logic [31:0] bs0;
        logic [31:0] bs1;
        logic [31:0] ch;
        logic [31:0] mj;
        w14   = wd(blk_reg, 14);
        w1    = wd(blk_reg, 1);
        s0    = ror(w14, 7) ^ ror(w14, 18) ^ (w14 >> 3);
        s1    = ror(w1, 17) ^ ror(w1, 19) ^ (w1 >> 10);
        w_new = s1 + wd(blk_reg, 6) + s0 + wd(blk_reg, 15);
        bs1   = ror(v_reg[4], 6) ^ ror(v_reg[4], 11) ^ ror(v_reg[4], 25);
        ch    = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        t1    = v_reg[7] + bs1 + ch + ROUND_K[round_reg] + wd(blk_reg, 15);
        bs0   = ror(v_reg[0], 2) ^ ror(v_reg[0], 13) ^ ror(v_reg[0], 22);
        mj    = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t2    = bs0 + mj;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_beat)
                begin
                    if (item.kind == KIND_FINISH)
                    begin
                        state_next = ST_PAD;
                    end
                    else if (fill_reg == 6'd63)
                    begin
                        state_next = ST_COMP;
                    end
                end
            end
            ST_PAD:
            begin
                if (fill_reg == 6'd63)
                begin
                    state_next = ST_COMP;
                end
            end
            ST_COMP:
            begin
                if (round_reg == 6'd63)
                begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                if (final_reg)
                begin
                    state_next = ST_LOAD;
                end
                else if (len_ok_reg)
                begin
                    state_next = ST_PAD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_LOAD:
            begin
                if (!out_busy_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath
    always_comb
    begin
        fill_next      = fill_reg;
        round_next     = round_reg;
        msg_bits_next  = msg_bits_reg;
        pad_first_next = pad_first_reg;
        len_ok_next    = len_ok_reg;
        final_next     = final_reg;
        out_busy_next  = out_busy_reg;
        out_idx_next   = out_idx_reg;
        blk_next       = blk_reg;
        hash_next      = hash_reg;
        v_next         = v_reg;
        out_buf_next   = out_buf_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (item_beat)
                begin
                    if (item.kind == KIND_FINISH)
                    begin
                        pad_first_next = 1'b1;
                        len_ok_next    = 1'b0;
                        final_next     = 1'b0;
                    end
                    else
                    begin
                        blk_next      = {blk_reg[503:0], item.data_byte};
                        fill_next     = fill_reg + 6'd1;
                        msg_bits_next = msg_bits_reg + 64'd8;
                        if (fill_reg == 6'd63)
                        begin
                            v_next     = hash_reg;
                            round_next = 6'd0;
                        end
                    end
                end
            end
            ST_PAD:
            begin
                blk_next       = {blk_reg[503:0], pad_byte};
                fill_next      = fill_reg + 6'd1;
                pad_first_next = 1'b0;
                if (use_len)
                begin
                    msg_bits_next = {msg_bits_reg[55:0], 8'h00};
                end
                if (pad_first_reg)
                begin
                    len_ok_next = (fill_reg[5:3] != 3'b111);
                end
                if (fill_reg == 6'd63)
                begin
                    v_next     = hash_reg;
                    round_next = 6'd0;
                    if (len_ok_reg)
                    begin
                        final_next = 1'b1;
                    end
                    else
                    begin
                        len_ok_next = 1'b1;
                    end
                end
            end
            ST_COMP:
            begin
                blk_next   = {blk_reg[479:0], w_new};
                round_next = round_reg + 6'd1;
                v_next[0]  = t1 + t2;
                v_next[1]  = v_reg[0];
                v_next[2]  = v_reg[1];
                v_next[3]  = v_reg[2];
                v_next[4]  = v_reg[3] + t1;
                v_next[5]  = v_reg[4];
                v_next[6]  = v_reg[5];
                v_next[7]  = v_reg[6];
            end
            ST_ADD:
            begin
                for (int i = 0; i < 8; i++)
                begin
                    hash_next[i] = hash_reg[i] + v_reg[i];
                end
            end
            ST_LOAD:
            begin
                if (!out_busy_reg)
                begin
                    out_buf_next  = hash_reg;
                    out_busy_next = 1'b1;
                    out_idx_next  = 3'd0;
                    hash_next     = INIT_H;
                    len_ok_next   = 1'b0;
                    final_next    = 1'b0;
                end
            end
            default:
            begin
            end
        endcase

        // digest drain
        if (result_beat)
        begin
            for (int i = 0; i < 7; i++)
            begin
                out_buf_next[i] = out_buf_reg[i+1];
            end
            out_idx_next = out_idx_reg + 3'd1;
            if (out_idx_reg == 3'd7)
            begin
                out_busy_next = 1'b0;
            end
        end
    end

    // outputs
    always_comb
    begin
        item_stall         = (state_reg != ST_IDLE);
        result_valid       = out_busy_reg;
        result.digest_word = out_buf_reg[0];
        result.word_index  = out_idx_reg;
        result.last_word   = (out_idx_reg == 3'd7);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= 6'd0;
            round_reg     <= 6'd0;
            msg_bits_reg  <= 64'd0;
            pad_first_reg <= 1'b0;
            len_ok_reg    <= 1'b0;
            final_reg     <= 1'b0;
            out_busy_reg  <= 1'b0;
            out_idx_reg   <= 3'd0;
            hash_reg      <= INIT_H;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            round_reg     <= round_next;
            msg_bits_reg  <= msg_bits_next;
            pad_first_reg <= pad_first_next;
            len_ok_reg    <= len_ok_next;
            final_reg     <= final_next;
            out_busy_reg  <= out_busy_next;
            out_idx_reg   <= out_idx_next;
            hash_reg      <= hash_next;
        end
    end

    always_ff @(posedge clk)
    begin
        blk_reg     <= blk_next;
        v_reg       <= v_next;
        out_buf_reg <= out_buf_next;
    end

`ifndef ASSERT_OFF
    a_last_beat_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (result_beat && result.last_word) |=> !result_valid)
        else $error("digest beats continue after the last word");

    a_rounds_then_add: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COMP && round_reg == 6'd63) |=> (state_reg == ST_ADD))
        else $error("compression did not end after 64 rounds");

    a_load_starts_digest: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOAD && !out_busy_reg) |=>
        (result_valid && result.word_index == 3'd0))
        else $error("digest load did not start at word zero");

    a_final_needs_len: assert property (@(posedge clk) disable iff (!rst_n)
        final_reg |-> len_ok_reg)
        else $error("final block flagged before length phase");
`endif

endmodule
